// File: hw/rtl/arpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types and constants of the address-resolution cache
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned IpW      = 32;
  localparam int unsigned MacW     = 48;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 56;

  localparam logic OpLookup = 1'b0;
  localparam logic OpInsert = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESOLVE
  } arpc_state_e;

  // control from the sequencer to one cell
  typedef struct packed {
    logic shift;
    logic capture;
    logic filled;
  } arpc_cell_ctrl_t;

endpackage

// File: hw/rtl/arpc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_cell
// one table entry: holds an address pair, compares it with the search key
// and hands its pair on to the next cell when a new entry is shifted in
// ----------------------------------------------------------------------------
module arpc_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  arpc_pkg::arpc_cell_ctrl_t    ctrl_i,
  input  logic [arpc_pkg::IpW-1:0]     key_ip_i,
  input  logic [arpc_pkg::IpW-1:0]     prev_ip_i,
  input  logic [arpc_pkg::MacW-1:0]    prev_mac_i,
  output logic [arpc_pkg::IpW-1:0]     ip_o,
  output logic [arpc_pkg::MacW-1:0]    mac_o,
  output logic                         hit_o,
  output logic [arpc_pkg::MacW-1:0]    hit_mac_o
);
  import arpc_pkg::*;

  logic [IpW-1:0]  ip_q;
  logic [MacW-1:0] mac_q;
  logic            hit_q, hit_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      ip_q  <= prev_ip_i;
      mac_q <= prev_mac_i;
    end
  end

  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.capture) begin
      hit_d = ctrl_i.filled && (ip_q == key_ip_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign ip_o      = ip_q;
  assign mac_o     = mac_q;
  assign hit_o     = hit_q;
  assign hit_mac_o = hit_q ? mac_q : '0;

endmodule

// File: hw/rtl/arp_address_cache_top.sv
`timescale 1ns / 1ps
// each item is taken in idle, compared in all cells in match and resolved
// in resolve, where its result is registered; a new item is taken only in idle
// a waiting result does not block the next item; resolve waits for a free output
// reset clears the fill count and all control state; entries hold no reset value
// ----------------------------------------------------------------------------
// arp_address_cache_top
// ipv4 to mac address cache built as a row of entry cells, new entries
// shifted in at the head, all cells compared in parallel
// ----------------------------------------------------------------------------
module arp_address_cache_top #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // ip_address[31:0], mac_address[79:32]
  input  logic [arpc_pkg::InDataW-1:0]      s_axis_tdata,
  // operation[0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // found[0], found_mac[48:1], inserted[49], table_full[50], zero[55:51]
  output logic [arpc_pkg::OutDataW-1:0]     m_axis_tdata
);
  import arpc_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  arpc_state_e     state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            op_q;
  logic [IpW-1:0]  key_ip_q;
  logic [MacW-1:0] key_mac_q;
  logic            m_valid_q, m_valid_d;
  logic [OutDataW-1:0] res_q, res_d;

  logic            accept, capture, shift, out_load, tbl_full;
  logic            any_hit;
  logic [MacW-1:0] any_mac;

  logic [IpW-1:0]  cell_ip   [TABLE_ENTRIES];
  logic [MacW-1:0] cell_mac  [TABLE_ENTRIES];
  logic [MacW-1:0] cell_hmac [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] cell_hit;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign tbl_full = (fill_q == CntW'(TABLE_ENTRIES));

  // row of cells
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    arpc_cell_ctrl_t ctrl;
    logic [IpW-1:0]  prev_ip;
    logic [MacW-1:0] prev_mac;

    assign ctrl.shift   = shift;
    assign ctrl.capture = capture;
    assign ctrl.filled  = (fill_q > CntW'(i));

    if (i == 0) begin : g_head
      assign prev_ip  = key_ip_q;
      assign prev_mac = key_mac_q;
    end else begin : g_body
      assign prev_ip  = cell_ip[i-1];
      assign prev_mac = cell_mac[i-1];
    end

    arpc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .key_ip_i   (key_ip_q),
      .prev_ip_i  (prev_ip),
      .prev_mac_i (prev_mac),
      .ip_o       (cell_ip[i]),
      .mac_o      (cell_mac[i]),
      .hit_o      (cell_hit[i]),
      .hit_mac_o  (cell_hmac[i])
    );
  end

  // at most one cell hits, so the masked macs are simply or-ed
  always_comb begin
    any_mac = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      any_mac = any_mac | cell_hmac[i];
    end
  end
  assign any_hit = |cell_hit;

  // sequencer
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    capture       = 1'b0;
    shift         = 1'b0;
    out_load      = 1'b0;
    fill_d        = fill_q;
    res_d         = '0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: begin
        capture = 1'b1;
        state_d = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          res_d[0]      = any_hit;
          res_d[MacW:1] = any_mac;
          if (!any_hit && (op_q == OpInsert)) begin
            if (tbl_full) begin
              res_d[MacW+2] = 1'b1;
            end else begin
              res_d[MacW+1] = 1'b1;
              shift         = 1'b1;
              fill_d        = fill_q + CntW'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= s_axis_tuser;
      key_ip_q  <= s_axis_tdata[IpW-1:0];
      key_mac_q <= s_axis_tdata[IpW+MacW-1:IpW];
    end
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = res_q;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_hit))
    else $error("address held in more than one cell");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (m_axis_tvalid && m_axis_tdata[MacW+1]))
    else $error("fill count moved without an inserted result");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && (m_axis_tdata[MacW+1] || m_axis_tdata[MacW+2])))
    else $error("found result also flagged as insert or full");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_MATCH))
    else $error("item taken without starting a compare");
`endif

endmodule

// File: tb/sv/tb_arp_address_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arp_address_cache_top
// self-checking bench for the ipv4 to mac address cache. lookups and inserts
// are streamed in with random gaps and output stalls. a local copy of the
// table predicts found, found mac, inserted and table full for every item,
// and each reply is compared against it in order.
// ----------------------------------------------------------------------------
module tb_arp_address_cache_top;

  import arpc_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned RUN_LIMIT     = 250_000;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef struct {
    logic            found;
    logic [MacW-1:0] found_mac;
    logic            inserted;
    logic            table_full;
  } arp_reply_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = OpLookup;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  logic [IpW-1:0]  cache_ip  [TABLE_ENTRIES];
  logic [MacW-1:0] cache_mac [TABLE_ENTRIES];
  int unsigned     cache_fill = 0;

  arp_reply_t  pending_replies[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int          gap_max     = 0;
  int          stall_max   = 0;
  int          ready_hold  = 0;
  int unsigned reply_count = 0;
  int unsigned drawn_count = 0;

  arp_address_cache_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("arp_address_cache_top regression: fail");
    $finish;
  end

  // lowest matching slot wins, new address appended while there is room
  function automatic arp_reply_t resolve_address(logic op, logic [IpW-1:0] ip,
                                                 logic [MacW-1:0] mac);
    arp_reply_t reply;
    int         slot;
    reply.found      = 1'b0;
    reply.found_mac  = '0;
    reply.inserted   = 1'b0;
    reply.table_full = 1'b0;
    slot = -1;
    for (int i = 0; i < int'(cache_fill); i++) begin
      if (slot < 0 && cache_ip[i] == ip) slot = i;
    end
    if (slot >= 0) begin
      reply.found     = 1'b1;
      reply.found_mac = cache_mac[slot];
    end else if (op == OpInsert) begin
      if (cache_fill < TABLE_ENTRIES) begin
        cache_ip[cache_fill]  = ip;
        cache_mac[cache_fill] = mac;
        cache_fill++;
        reply.inserted = 1'b1;
      end else begin
        reply.table_full = 1'b1;
      end
    end
    return reply;
  endfunction

  function automatic logic [MacW-1:0] random_mac();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[MacW-1:0];
  endfunction

  // stored address, stored address with one bit flipped, or a fresh one
  function automatic logic [IpW-1:0] pick_ip(int stored_pct, int near_pct);
    int             roll;
    logic [IpW-1:0] base;
    roll = $urandom_range(0, 99);
    if (cache_fill == 0 || roll >= stored_pct + near_pct) return $urandom;
    base = cache_ip[$urandom_range(0, cache_fill - 1)];
    if (roll < stored_pct) return base;
    return base ^ (32'd1 << $urandom_range(0, IpW - 1));
  endfunction

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic send_item(input logic op, input logic [IpW-1:0] ip,
                           input logic [MacW-1:0] mac);
    int gap;
    gap = $urandom_range(0, gap_max);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {mac, ip};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_replies.push_back(resolve_address(op, ip, mac));
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_for_replies();
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // rotate through busy, bursty and stalled phases on both sides
  task automatic set_idling(input int block);
    case (block % 4)
      0: begin
        gap_max   = 9;
        stall_max = 9;
      end
      1: begin
        gap_max   = 0;
        stall_max = 0;
      end
      2: begin
        gap_max   = 0;
        stall_max = 9;
      end
      default: begin
        gap_max   = 9;
        stall_max = 0;
      end
    endcase
  endtask

  task automatic random_item(input int insert_pct, input int ins_stored,
                             input int ins_near, input int look_stored,
                             input int look_near);
    logic op;
    op = ($urandom_range(0, 99) < insert_pct) ? OpInsert : OpLookup;
    if (op == OpInsert) send_item(op, pick_ip(ins_stored, ins_near), random_mac());
    else send_item(op, pick_ip(look_stored, look_near), random_mac());
  endtask

  task automatic test_empty_table();
    gap_max   = 3;
    stall_max = 3;
    send_item(OpLookup, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    send_item(OpLookup, 32'hFFFF_FFFF, 48'h0000_0000_0000);
    send_item(OpInsert, 32'h0000_0000, 48'h0000_0000_0000);
    send_item(OpInsert, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    // repeated insert keeps the first mac
    send_item(OpInsert, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    send_item(OpLookup, 32'h0000_0000, 48'h5555_5555_5555);
    send_item(OpLookup, 32'hFFFF_FFFF, 48'hAAAA_AAAA_AAAA);
    send_item(OpLookup, 32'h8000_0001, 48'h0000_0000_0000);
  endtask

  task automatic test_random_filling();
    for (int n = 0; n < 300; n++) begin
      if (n % 50 == 0) set_idling(n / 50);
      random_item(50, 90, 4, 60, 20);
    end
    wait_for_replies();
  endtask

  task automatic test_full_table();
    gap_max   = 2;
    stall_max = 2;
    while (cache_fill < TABLE_ENTRIES) send_item(OpInsert, $urandom, random_mac());
    // new address into a full table is dropped
    send_item(OpInsert, 32'h5A5A_A5A5, random_mac());
    send_item(OpInsert, cache_ip[0], random_mac());
    send_item(OpLookup, cache_ip[TABLE_ENTRIES - 1], random_mac());
    send_item(OpLookup, cache_ip[0], random_mac());
    send_item(OpLookup, 32'h5A5A_A5A5, random_mac());
    wait_for_replies();
  endtask

  task automatic test_random_full();
    for (int n = 0; n < 600; n++) begin
      if (n % 50 == 0) set_idling(n / 50 + 1);
      if (n % 150 == 149 || $urandom_range(0, 99) == 0) wait_for_replies();
      random_item(50, 70, 10, 50, 25);
    end
  endtask

  // a fresh stall is drawn for every reply taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (drawn_count != reply_count) begin
        drawn_count = reply_count;
        ready_hold  = $urandom_range(0, stall_max);
      end
      if (ready_hold > 0) begin
        m_axis_tready <= 1'b0;
        ready_hold    = ready_hold - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : reply_check
    arp_reply_t want;
    arp_reply_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      reply_count++;
      got.found      = m_axis_tdata[0];
      got.found_mac  = m_axis_tdata[MacW:1];
      got.inserted   = m_axis_tdata[MacW+1];
      got.table_full = m_axis_tdata[MacW+2];
      if (pending_replies.size() == 0) begin
        note_failure($sformatf("reply with nothing outstanding, data %h", m_axis_tdata));
      end else begin
        want = pending_replies.pop_front();
        if (got.found !== want.found)
          note_failure($sformatf("found exp %b got %b", want.found, got.found));
        if (got.found_mac !== want.found_mac)
          note_failure($sformatf("found_mac exp %h got %h", want.found_mac,
                                 got.found_mac));
        if (got.inserted !== want.inserted)
          note_failure($sformatf("inserted exp %b got %b", want.inserted, got.inserted));
        if (got.table_full !== want.table_full)
          note_failure($sformatf("table_full exp %b got %b", want.table_full,
                                 got.table_full));
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_table();
    test_random_filling();
    test_full_table();
    test_random_full();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("arp_address_cache_top regression: pass");
    end else begin
      $display("arp_address_cache_top regression: fail");
    end
    $finish;
  end

endmodule
